// ----- sv/kmsd_pkg.sv -----
package kmsd_pkg;

    localparam int unsigned ROWS_DEFAULT = 16;
    localparam int unsigned COLS_DEFAULT = 16;

    localparam int unsigned ROW_IDX_W = 4;
    localparam int unsigned COL_W     = 16;
    localparam int unsigned SCAN_W    = 8;
    localparam int unsigned TOTAL_W   = 9;
    localparam int unsigned POP_W     = 5;

    localparam logic [SCAN_W-1:0]  DEBOUNCE_RESET = 8'd5;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX      = 9'd511;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RAW,
        S_CP_RD,
        S_CP_WR,
        S_ST_RD,
        S_OUT
    } t_state;

    function automatic logic [POP_W-1:0] popcount(input logic [COL_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int i = 0; i < int'(COL_W); i++) begin
            n = n + POP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ----- sv/kmsd_row_mem.sv -----
module kmsd_row_mem #(
    parameter int unsigned ROWS  = kmsd_pkg::ROWS_DEFAULT,
    parameter int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [ROW_W-1:0]           i_waddr,
    input  logic [kmsd_pkg::COL_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ROW_W-1:0]           i_raddr,
    output logic [kmsd_pkg::COL_W-1:0] o_rdata
);

    logic [kmsd_pkg::COL_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]            r_valid;
    logic [kmsd_pkg::COL_W-1:0] r_q;
    logic                       r_qv;

    // An entry that was never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_qv <= r_valid[i_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule

// ----- sv/key_matrix_scan_debouncer.sv -----
// Key matrix debouncer with one shared countdown. Each input word is one row's active-high
// column reading, its row index and an end-of-scan flag; each accepted word yields exactly one
// output word with the debounced row, the settled flag, the pressed-key total and a bounce flag.
// A word normally passes through accept with raw sample read, compare and write-back, stable
// read, then load of the output register. On the end of scan where the countdown reaches zero
// the whole raw matrix is copied into the stable matrix row by row, each row read and then
// written, before that word goes on. A finished word waits to load the output register while
// that register still holds a word that was not taken. The raw and stable rows live in two
// single-port-write, single-read memories with registered read data. The user must write the
// debounce_scans register through the configuration port only while the block is idle; the
// block itself does not enforce this. The new value takes effect at the next reload.
module key_matrix_scan_debouncer #(
    parameter int unsigned ROWS = kmsd_pkg::ROWS_DEFAULT,
    parameter int unsigned COLS = kmsd_pkg::COLS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kmsd_pkg::SCAN_W-1:0]      i_cfg_debounce_scans,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [kmsd_pkg::ROW_IDX_W-1:0]   i_row_index,
    input  logic [kmsd_pkg::COL_W-1:0]       i_column_bits,
    input  logic                             i_scan_end,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [kmsd_pkg::COL_W-1:0]       o_stable_row,
    output logic                             o_settled,
    output logic [kmsd_pkg::TOTAL_W-1:0]     o_pressed_count,
    output logic                             o_bounce_seen
);

    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned IDX_W = (ROW_W > kmsd_pkg::ROW_IDX_W) ? ROW_W : kmsd_pkg::ROW_IDX_W;
    localparam int unsigned SUM_W = $clog2(ROWS * kmsd_pkg::COL_W + 1);
    localparam logic [kmsd_pkg::ROW_IDX_W+1:0] ROWS_LIM = (kmsd_pkg::ROW_IDX_W + 2)'(ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [kmsd_pkg::COL_W-1:0] COL_MASK = (COLS >= kmsd_pkg::COL_W) ?
        '1 : kmsd_pkg::COL_W'((32'd1 << COLS) - 32'd1);

    kmsd_pkg::t_state r_state, n_state;

    logic [kmsd_pkg::SCAN_W-1:0]  r_debounce;
    logic [kmsd_pkg::SCAN_W-1:0]  r_cd, n_cd;
    logic [kmsd_pkg::TOTAL_W-1:0] r_total, n_total;
    logic [SUM_W-1:0]             r_sum, n_sum;
    logic [ROW_W-1:0]             r_idx, n_idx;
    logic                         r_bounce, n_bounce;

    logic [ROW_W-1:0]             r_row;
    logic                         r_inr;
    logic [kmsd_pkg::COL_W-1:0]   r_cols;
    logic                         r_end;

    logic                         r_out_valid, n_out_valid;
    logic [kmsd_pkg::COL_W-1:0]   r_o_row;
    logic                         r_o_settled;
    logic [kmsd_pkg::TOTAL_W-1:0] r_o_count;
    logic                         r_o_bounce;
    logic                         load_out;

    logic [IDX_W-1:0]             row_ext;
    logic                         accept;

    logic                         raw_we, raw_re;
    logic [ROW_W-1:0]             raw_raddr;
    logic [kmsd_pkg::COL_W-1:0]   raw_rdata;
    logic                         st_we, st_re;
    logic [kmsd_pkg::COL_W-1:0]   st_rdata;

    logic                         changed;
    logic [kmsd_pkg::SCAN_W-1:0]  reload;
    logic [kmsd_pkg::SCAN_W-1:0]  cd_a;
    logic [SUM_W-1:0]             sum_next;

    assign row_ext = IDX_W'(i_row_index);
    assign accept  = i_in_valid && (r_state == kmsd_pkg::S_IDLE);

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != kmsd_pkg::S_IDLE);

    assign raw_re    = accept || (r_state == kmsd_pkg::S_CP_RD);
    assign raw_raddr = (r_state == kmsd_pkg::S_IDLE) ? row_ext[ROW_W-1:0] : r_idx;

    kmsd_row_mem #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_raw_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (raw_we),
        .i_waddr (r_row),
        .i_wdata (r_cols),
        .i_re    (raw_re),
        .i_raddr (raw_raddr),
        .o_rdata (raw_rdata)
    );

    assign st_re = (r_state == kmsd_pkg::S_ST_RD);

    kmsd_row_mem #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_stable_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_waddr (r_idx),
        .i_wdata (raw_rdata),
        .i_re    (st_re),
        .i_raddr (r_row),
        .o_rdata (st_rdata)
    );

    assign changed  = r_inr && (raw_rdata != r_cols);
    assign reload   = (r_debounce == '0) ? kmsd_pkg::SCAN_W'(1) : r_debounce;
    assign cd_a     = changed ? reload : r_cd;
    assign sum_next = r_sum + SUM_W'(kmsd_pkg::popcount(raw_rdata));

    always_comb begin
        n_state     = r_state;
        n_cd        = r_cd;
        n_total     = r_total;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_bounce    = r_bounce;
        n_out_valid = r_out_valid;
        raw_we      = 1'b0;
        st_we       = 1'b0;
        load_out    = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            kmsd_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = kmsd_pkg::S_RAW;
                end
            end
            kmsd_pkg::S_RAW: begin
                raw_we   = changed;
                n_bounce = changed && (r_cd != '0);
                n_cd     = cd_a;
                n_state  = kmsd_pkg::S_ST_RD;
                if (r_end && (cd_a != '0)) begin
                    n_cd = cd_a - kmsd_pkg::SCAN_W'(1);
                    if (cd_a == kmsd_pkg::SCAN_W'(1)) begin
                        n_idx   = '0;
                        n_sum   = '0;
                        n_state = kmsd_pkg::S_CP_RD;
                    end
                end
            end
            kmsd_pkg::S_CP_RD: begin
                n_state = kmsd_pkg::S_CP_WR;
            end
            kmsd_pkg::S_CP_WR: begin
                st_we = 1'b1;
                n_sum = sum_next;
                if (r_idx == LAST_ROW) begin
                    n_total = (sum_next > SUM_W'(kmsd_pkg::TOTAL_MAX)) ?
                        kmsd_pkg::TOTAL_MAX : kmsd_pkg::TOTAL_W'(sum_next);
                    n_state = kmsd_pkg::S_ST_RD;
                end else begin
                    n_idx   = r_idx + ROW_W'(1);
                    n_state = kmsd_pkg::S_CP_RD;
                end
            end
            kmsd_pkg::S_ST_RD: begin
                n_state = kmsd_pkg::S_OUT;
            end
            kmsd_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = kmsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kmsd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kmsd_pkg::S_IDLE;
            r_debounce  <= kmsd_pkg::DEBOUNCE_RESET;
            r_cd        <= kmsd_pkg::DEBOUNCE_RESET;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cd        <= n_cd;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_debounce <= i_cfg_debounce_scans;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_idx    <= n_idx;
        r_bounce <= n_bounce;
        if (accept) begin
            r_row  <= row_ext[ROW_W-1:0];
            r_inr  <= ({2'b00, i_row_index} < ROWS_LIM);
            r_cols <= i_column_bits & COL_MASK;
            r_end  <= i_scan_end;
        end
        if (load_out) begin
            r_o_row     <= r_inr ? st_rdata : '0;
            r_o_settled <= (r_cd == '0);
            r_o_count   <= r_total;
            r_o_bounce  <= r_bounce;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stable_row    = r_o_row;
    assign o_settled       = r_o_settled;
    assign o_pressed_count = r_o_count;
    assign o_bounce_seen   = r_o_bounce;

endmodule

// ----- tb/key_matrix_scan_debouncer_tb.sv -----
`timescale 1ns / 1ps

module key_matrix_scan_debouncer_tb;

    localparam int unsigned ROWS = kmsd_pkg::ROWS_DEFAULT;
    localparam int unsigned COLS = kmsd_pkg::COLS_DEFAULT;
    localparam logic [kmsd_pkg::COL_W-1:0] COL_MASK =
        kmsd_pkg::COL_W'((64'd1 << COLS) - 64'd1);

    localparam int unsigned DRAIN_CYCLES   = 2 * ROWS + 16;
    localparam int unsigned LONG_HOLD_AT   = 400;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SCANS_PER_SET  = 12;

    typedef struct packed {
        logic [kmsd_pkg::ROW_IDX_W-1:0] row;
        logic [kmsd_pkg::COL_W-1:0]     cols;
        logic                           scan_end;
    } t_scan_word;

    typedef struct packed {
        logic [kmsd_pkg::COL_W-1:0]   stable_row;
        logic                         settled;
        logic [kmsd_pkg::TOTAL_W-1:0] pressed;
        logic                         bounce;
    } t_debounce_word;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        cfg_valid = 1'b0;
    logic [kmsd_pkg::SCAN_W-1:0] debounce_wr = '0;
    logic                        o_cfg_ready;

    logic       in_valid = 1'b0;
    t_scan_word in_word = '0;
    logic       o_in_stall;

    logic                         out_stall = 1'b0;
    logic                         o_out_valid;
    logic [kmsd_pkg::COL_W-1:0]   o_stable_row;
    logic                         o_settled;
    logic [kmsd_pkg::TOTAL_W-1:0] o_pressed_count;
    logic                         o_bounce_seen;

    t_scan_word     word_q[$];
    t_debounce_word settle_expect_q[$];

    logic [kmsd_pkg::COL_W-1:0]   raw_model[ROWS];
    logic [kmsd_pkg::COL_W-1:0]   stable_model[ROWS];
    logic [kmsd_pkg::SCAN_W-1:0]  countdown_model;
    logic [kmsd_pkg::SCAN_W-1:0]  debounce_setting;
    logic [kmsd_pkg::TOTAL_W-1:0] total_model;

    logic [kmsd_pkg::COL_W-1:0] press_map[ROWS];

    int unsigned errors = 0;
    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes = 0;
    int unsigned copies = 0;
    int unsigned bounces = 0;
    int unsigned tx_gap = 0;
    int unsigned tx_burst = 0;
    int unsigned rx_hold = 0;
    int unsigned rx_burst = 0;
    int unsigned quiet = 0;

    key_matrix_scan_debouncer dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_debounce_scans (debounce_wr),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_row_index          (in_word.row),
        .i_column_bits        (in_word.cols),
        .i_scan_end           (in_word.scan_end),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_stable_row         (o_stable_row),
        .o_settled            (o_settled),
        .o_pressed_count      (o_pressed_count),
        .o_bounce_seen        (o_bounce_seen)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic int unsigned idle_draw(inout int unsigned burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic t_debounce_word debounce_predict(input t_scan_word w);
        t_debounce_word r;
        logic [kmsd_pkg::COL_W-1:0] cols;
        int unsigned total;
        r = '0;
        cols = w.cols & COL_MASK;
        if (w.row < ROWS) begin
            if (raw_model[w.row] != cols) begin
                raw_model[w.row] = cols;
                r.bounce = (countdown_model != 0);
                if (r.bounce) begin
                    bounces++;
                end
                countdown_model = (debounce_setting == 0) ?
                    kmsd_pkg::SCAN_W'(1) : debounce_setting;
            end
        end
        if (w.scan_end && countdown_model != 0) begin
            countdown_model = countdown_model - 1'b1;
            if (countdown_model == 0) begin
                total = 0;
                for (int i = 0; i < int'(ROWS); i++) begin
                    stable_model[i] = raw_model[i];
                    total += $countones(raw_model[i]);
                end
                total_model = (total > kmsd_pkg::TOTAL_MAX) ?
                    kmsd_pkg::TOTAL_MAX : kmsd_pkg::TOTAL_W'(total);
                copies++;
            end
        end
        if (w.row < ROWS) begin
            r.stable_row = stable_model[w.row];
        end
        r.settled = (countdown_model == 0);
        r.pressed = total_model;
        return r;
    endfunction

    // Sender: one word in flight, payload held while stalled.
    always @(posedge clk) begin
        int unsigned g;
        t_scan_word nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap <= 0;
        end else if (in_valid && !o_in_stall) begin
            settle_expect_q.push_back(debounce_predict(in_word));
            words_sent++;
            g = idle_draw(tx_burst);
            if (g == 0 && word_q.size() > 0) begin
                nxt = word_q.pop_front();
                in_word <= nxt;
            end else begin
                in_valid <= 1'b0;
                tx_gap <= g;
            end
        end else if (!in_valid) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
            end else if (word_q.size() > 0) begin
                nxt = word_q.pop_front();
                in_word <= nxt;
                in_valid <= 1'b1;
            end
        end
    end

    // Receiver: checks each result word and draws its own stall.
    always @(posedge clk) begin
        int unsigned h;
        t_debounce_word exp_w;
        h = rx_hold;
        if (rst_n && o_out_valid && !out_stall) begin
            results_checked++;
            if (settle_expect_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result word: row %h settled %b count %0d bounce %b",
                             o_stable_row, o_settled, o_pressed_count, o_bounce_seen);
                end
            end else begin
                exp_w = settle_expect_q.pop_front();
                if (o_stable_row !== exp_w.stable_row || o_settled !== exp_w.settled ||
                    o_pressed_count !== exp_w.pressed || o_bounce_seen !== exp_w.bounce) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at result %0d:", results_checked);
                        $display("    expected row %h settled %b count %0d bounce %b",
                                 exp_w.stable_row, exp_w.settled,
                                 exp_w.pressed, exp_w.bounce);
                        $display("    actual row %h settled %b count %0d bounce %b",
                                 o_stable_row, o_settled, o_pressed_count, o_bounce_seen);
                    end
                end
            end
            h = (results_checked == LONG_HOLD_AT) ? LONG_HOLD : idle_draw(rx_burst);
        end
        if (h > 0) begin
            out_stall <= 1'b1;
            rx_hold <= h - 1;
        end else begin
            out_stall <= 1'b0;
            rx_hold <= 0;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == WATCHDOG_LIMIT) begin
            $display("** key_matrix_scan_debouncer: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_word(input int unsigned row, input logic [kmsd_pkg::COL_W-1:0] cols,
                             input logic scan_end);
        t_scan_word w;
        w.row = kmsd_pkg::ROW_IDX_W'(row);
        w.cols = cols;
        w.scan_end = scan_end;
        word_q.push_back(w);
    endtask

    // Sampled on the falling edge so that the sender's queue and valid have settled.
    task automatic drain();
        @(negedge clk);
        while (word_q.size() != 0 || in_valid || settle_expect_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [kmsd_pkg::SCAN_W-1:0] v);
        drain();
        debounce_wr <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!o_cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        debounce_setting = v;
        cfg_writes++;
    endtask

    task automatic send_scan(input int unsigned last_row, input bit glitchy);
        logic [kmsd_pkg::COL_W-1:0] v;
        for (int unsigned r = 0; r <= last_row; r++) begin
            v = press_map[r];
            if (glitchy && $urandom_range(0, 23) == 0) begin
                v = v ^ kmsd_pkg::COL_W'($urandom());
            end
            push_word(r, v, r == last_row);
        end
    endtask

    task automatic random_phase(input logic [kmsd_pkg::SCAN_W-1:0] setting);
        int unsigned k;
        int unsigned r;
        write_debounce(setting);
        repeat (SCANS_PER_SET) begin
            k = $urandom_range(0, 19);
            r = $urandom_range(0, ROWS - 1);
            if (k == 0) begin
                foreach (press_map[i]) press_map[i] = '1;
            end else if (k == 1) begin
                foreach (press_map[i]) press_map[i] = '0;
            end else if (k < 8) begin
                press_map[r] = press_map[r] ^
                    (kmsd_pkg::COL_W'(1) << $urandom_range(0, kmsd_pkg::COL_W - 1));
            end else if (k == 8) begin
                press_map[r] = kmsd_pkg::COL_W'($urandom());
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    push_word($urandom_range(0, ROWS - 1), kmsd_pkg::COL_W'($urandom()),
                              1'($urandom_range(0, 1)));
                end
            end else if ($urandom_range(0, 11) == 0) begin
                send_scan($urandom_range(0, ROWS - 1), 1'b1);
            end else begin
                send_scan(ROWS - 1, $urandom_range(0, 2) == 0);
            end
        end
    endtask

    initial begin
        logic [kmsd_pkg::SCAN_W-1:0] settings[8];
        logic [kmsd_pkg::COL_W-1:0] held;

        settings = '{8'd1, 8'd2, 8'd5, 8'd0, 8'd3, 8'd8, 8'd1, 8'd4};
        foreach (raw_model[i]) begin
            raw_model[i] = '0;
            stable_model[i] = '0;
            press_map[i] = '0;
        end
        countdown_model = kmsd_pkg::DEBOUNCE_RESET;
        debounce_setting = kmsd_pkg::DEBOUNCE_RESET;
        total_model = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: first changes bounce against the loaded countdown, then settle.
        push_word(0, 16'hFFFF, 1'b0);
        push_word(15, 16'h8001, 1'b1);
        repeat (4) push_word(0, 16'hFFFF, 1'b1);
        push_word(15, 16'h8001, 1'b0);
        push_word(3, 16'h5555, 1'b0);
        push_word(3, 16'hAAAA, 1'b1);
        push_word(3, 16'h0000, 1'b0);
        push_word(0, 16'h0000, 1'b0);
        push_word(15, 16'h0000, 1'b1);
        repeat (4) push_word(7, 16'h0000, 1'b1);

        // A zero setting behaves as one scan.
        write_debounce(8'd0);
        push_word(9, 16'hFFFF, 1'b1);
        push_word(10, 16'hFFFF, 1'b1);
        push_word(9, 16'h0001, 1'b0);
        push_word(9, 16'h0001, 1'b1);

        for (int i = 0; i < 3; i++) begin
            random_phase(settings[i]);
        end

        // Longest setting; a write mid-count must leave the running countdown alone.
        write_debounce(8'd255);
        held = ~raw_model[2];
        repeat (150) push_word(2, held, 1'b1);
        write_debounce(8'd2);
        repeat (110) push_word(2, held, 1'b1);

        for (int i = 3; i < 8; i++) begin
            random_phase(settings[i]);
        end

        drain();
        $display("sent %0d row words, checked %0d results, %0d register writes",
                 words_sent, results_checked, cfg_writes);
        $display("matrix copies seen: %0d, bounces seen: %0d", copies, bounces);
        if (errors == 0) begin
            $display("** key_matrix_scan_debouncer: PASSED **");
        end else begin
            $display("** key_matrix_scan_debouncer: FAILED **");
        end
        $finish;
    end

endmodule
